@@ hw/rtl/fbfl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_pkg
// shared types and codes of the fixed block free list allocator
// ----------------------------------------------------------------------------
package fbfl_pkg;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_RESET = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_RANGE     = 2'd2,
        STATUS_NONE_USED = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FETCH = 1'b1
    } state_t;

    localparam int unsigned INDEX_W = 8;
    localparam int unsigned COUNT_W = 9;

endpackage : fbfl_pkg
`default_nettype wire

@@ hw/rtl/fbfl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : fbfl_ram
`default_nettype wire

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// hands out and takes back equal blocks named by index, last in first out
// ----------------------------------------------------------------------------
// Blocks come first from a linked stack of freed blocks, whose links sit in a
// single-port-read link memory, then from the untouched run above the fresh
// mark, so a pool reset item takes effect at once without walking the memory.
// An allocate from the linked stack enters the fetch state, stalling the input
// while the registered link memory read yields the new list head. The result
// of an item is held in an output register; a new item is taken only once that
// register is free or is being taken in the same cycle. req_blocks is latched
// on req_blocks_we; each pool reset item loads it into the pool size, saturated
// to 1..min(POOL_BLOCKS,256), and reset sets the pool size to that upper bound.
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
#(
    parameter int POOL_BLOCKS = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_blocks_we,
    input  wire logic [COUNT_W-1:0] req_blocks,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [INDEX_W-1:0] block_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [1:0]         status,
    output logic      [INDEX_W-1:0] block_index_res,
    output logic      [COUNT_W-1:0] used_count,
    output logic      [COUNT_W-1:0] blocks_total
);

    localparam int ADDR_W     = $clog2(POOL_BLOCKS);
    localparam int SIZE_LIMIT = (POOL_BLOCKS < 256) ? POOL_BLOCKS : 256;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   req_blocks_reg;
    logic [COUNT_W-1:0]   active_total_reg, active_total_next;
    logic [INDEX_W-1:0]   list_head_reg, list_head_next;
    logic                 linked_empty_reg, linked_empty_next;
    logic [COUNT_W-1:0]   fresh_mark_reg, fresh_mark_next;
    logic [COUNT_W-1:0]   used_total_reg, used_total_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [INDEX_W-1:0]   index_res_reg, index_res_next;

    logic                 in_xfer;
    logic                 pop_linked;
    logic                 push_link;
    logic [COUNT_W-1:0]   sat_count;
    logic [COUNT_W-1:0]   used_inc;
    logic [INDEX_W-1:0]   link_rd_data;

    assign in_xfer   = in_valid && !in_stall;
    assign used_inc  = used_total_reg + COUNT_W'(1);

    always_comb
    begin
        sat_count = req_blocks_reg;
        if (req_blocks_reg == '0)
        begin
            sat_count = COUNT_W'(1);
        end
        else if (32'(req_blocks_reg) > SIZE_LIMIT)
        begin
            sat_count = COUNT_W'(SIZE_LIMIT);
        end
    end

    // item datapath
    always_comb
    begin
        active_total_next = active_total_reg;
        list_head_next    = list_head_reg;
        linked_empty_next = linked_empty_reg;
        fresh_mark_next   = fresh_mark_reg;
        used_total_next   = used_total_reg;
        status_next       = status_reg;
        index_res_next    = index_res_reg;
        out_valid_next    = out_valid_reg && out_stall;
        pop_linked        = 1'b0;
        push_link         = 1'b0;

        if (state_reg == ST_FETCH)
        begin
            list_head_next = link_rd_data;
        end

        if (in_xfer)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_OK;
            index_res_next = '0;
            case (kind_t'(kind))
                KIND_ALLOC:
                begin
                    if (!linked_empty_reg)
                    begin
                        pop_linked        = 1'b1;
                        index_res_next    = list_head_reg;
                        used_total_next   = used_inc;
                        linked_empty_next = (used_inc >= fresh_mark_reg);
                    end
                    else if (fresh_mark_reg < active_total_reg)
                    begin
                        index_res_next  = fresh_mark_reg[INDEX_W-1:0];
                        fresh_mark_next = fresh_mark_reg + COUNT_W'(1);
                        used_total_next = used_inc;
                    end
                    else
                    begin
                        status_next = STATUS_EMPTY;
                    end
                end
                KIND_FREE:
                begin
                    if ({1'b0, block_index} >= active_total_reg
                        || 32'(block_index) >= POOL_BLOCKS)
                    begin
                        status_next = STATUS_RANGE;
                    end
                    else if (used_total_reg == '0)
                    begin
                        status_next = STATUS_NONE_USED;
                    end
                    else
                    begin
                        push_link         = 1'b1;
                        list_head_next    = block_index;
                        linked_empty_next = 1'b0;
                        used_total_next   = used_total_reg - COUNT_W'(1);
                    end
                end
                KIND_RESET:
                begin
                    active_total_next = sat_count;
                    list_head_next    = '0;
                    linked_empty_next = 1'b1;
                    fresh_mark_next   = '0;
                    used_total_next   = '0;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_linked)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  in_stall = out_valid_reg && out_stall;
            ST_FETCH: in_stall = 1'b1;
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            req_blocks_reg   <= COUNT_W'(256);
            active_total_reg <= COUNT_W'(SIZE_LIMIT);
            list_head_reg    <= '0;
            linked_empty_reg <= 1'b1;
            fresh_mark_reg   <= '0;
            used_total_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_total_reg <= active_total_next;
            list_head_reg    <= list_head_next;
            linked_empty_reg <= linked_empty_next;
            fresh_mark_reg   <= fresh_mark_next;
            used_total_reg   <= used_total_next;
            out_valid_reg    <= out_valid_next;
            if (req_blocks_we)
            begin
                req_blocks_reg <= req_blocks;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        index_res_reg <= index_res_next;
    end

    fbfl_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (POOL_BLOCKS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (push_link),
        .wr_addr (ADDR_W'(block_index)),
        .wr_data (list_head_reg),
        .rd_en   (pop_linked),
        .rd_addr (ADDR_W'(list_head_reg)),
        .rd_data (link_rd_data)
    );

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign block_index_res = index_res_reg;
    assign used_count      = used_total_reg;
    assign blocks_total    = active_total_reg;

    // a pop from the linked stack always enters the fetch state for the link read
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && kind == KIND_ALLOC && !linked_empty_reg) |=> state_reg == ST_FETCH)
        else $error("linked pop did not enter fetch");

    // every transfer in leaves a result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg)
        else $error("accepted item produced no result");

    // blocks in use never exceed blocks handed out from the fresh run, nor the fresh mark the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        used_total_reg <= fresh_mark_reg && fresh_mark_reg <= active_total_reg)
        else $error("used, fresh and pool counts out of order");

    // the linked stack is empty exactly when every fresh block is in use
    assert property (@(posedge clk) disable iff (!rst_n)
        linked_empty_reg == (used_total_reg == fresh_mark_reg))
        else $error("linked empty flag disagrees with counts");

endmodule : fixed_block_free_list_allocator
`default_nettype wire
